// ===== rtl/dlf_pkg.sv =====
// ----------------------------------------------------------------------------
// dlf_pkg
// shared types and constants of the dense layer forward block
// ----------------------------------------------------------------------------
package dlf_pkg;

    // default sizes of the stores and default fraction width
    localparam int MAX_IN_DEF    = 256;
    localparam int MAX_OUT_DEF   = 64;
    localparam int FRAC_BITS_DEF = 12;

    // fixed field widths
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = 48;
    localparam int RES_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int IN_LEN_W   = 9;
    localparam int OUT_LEN_W  = 7;

    // op codes of an input item
    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_ELEM   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE   = 2'd2;

    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

endpackage

// ===== rtl/dense_layer_forward_top.sv =====
// ----------------------------------------------------------------------------
// dense_layer_forward_top
// fully connected layer inference, y = x * W + b, in signed q4.12 fixed point
// ----------------------------------------------------------------------------
// weight and bias writes and non-final vector elements are taken while idle
// the element at position input_length-1 starts a burst of output_length
// results; each result is summed on the shared mac and then held in the
// output register, one neuron at a time, as the weight ram has one read port
// synchronous active-low reset clears control state, config (lengths 1,
// bias on) and the bias valid bits; weight and input rams are not cleared
// ----------------------------------------------------------------------------
module dense_layer_forward_top #(
    parameter int MAX_IN    = dlf_pkg::MAX_IN_DEF,
    parameter int MAX_OUT   = dlf_pkg::MAX_OUT_DEF,
    parameter int FRAC_BITS = dlf_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input item channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_op,
    input  logic [7:0]                             s_row_index,
    input  logic [5:0]                             s_column_index,
    input  logic signed [dlf_pkg::VAL_W-1:0]       s_value,
    // result item channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [5:0]                             m_out_index,
    output logic signed [dlf_pkg::RES_W-1:0]       m_result_value,
    output logic                                   m_last,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]         cfg_data
);

    import dlf_pkg::*;

    // address widths of the stores
    localparam int IN_AW    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int IN_CNT_W = $clog2(MAX_IN + 1);
    localparam int OUT_AW   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int W_DEPTH  = MAX_IN * MAX_OUT;
    localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    logic [IN_LEN_W-1:0]  in_len_reg;
    logic [OUT_LEN_W-1:0] out_len_reg;
    logic                 bias_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_len_reg  <= IN_LEN_W'(1);
            out_len_reg <= OUT_LEN_W'(1);
            bias_en_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INPUT_LENGTH:  in_len_reg  <= cfg_data[IN_LEN_W-1:0];
                CFG_OUTPUT_LENGTH: out_len_reg <= cfg_data[OUT_LEN_W-1:0];
                CFG_BIAS_ENABLE:   bias_en_reg <= cfg_data[0];
                default:           ;   // unused index, write dropped
            endcase
        end
    end

    // effective lengths: zero acts as one, oversize clamps to the store size
    logic [IN_CNT_W-1:0] n_in;
    logic [6:0]          n_out;

    always_comb begin
        if (in_len_reg == '0) begin
            n_in = IN_CNT_W'(1);
        end else if (32'(in_len_reg) > 32'(MAX_IN)) begin
            n_in = IN_CNT_W'(MAX_IN);
        end else begin
            n_in = IN_CNT_W'(in_len_reg);
        end
        if (out_len_reg == '0) begin
            n_out = 7'd1;
        end else if (32'(out_len_reg) > 32'(MAX_OUT)) begin
            n_out = 7'(MAX_OUT);
        end else begin
            n_out = out_len_reg;
        end
    end

    // ------------------------------------------------------------------
    // input item decode
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic in_acc;
    logic row_ok, col_ok;
    logic wgt_wr, bias_wr, elem_wr, trigger;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;

    assign row_ok  = 32'(s_row_index) < 32'(MAX_IN);
    assign col_ok  = 32'(s_column_index) < 32'(MAX_OUT);
    assign wgt_wr  = in_acc && (s_op == OP_WEIGHT) && row_ok && col_ok;
    assign bias_wr = in_acc && (s_op == OP_BIAS) && col_ok;
    assign elem_wr = in_acc && (s_op == OP_ELEM) && row_ok;
    // the element in the final position starts the burst
    assign trigger = elem_wr && ((32'(s_row_index) + 32'd1) == 32'(n_in));

    // ------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------
    logic [IN_AW-1:0]  k_reg, k_next;         // element counter
    logic [OUT_AW-1:0] j_reg, j_next;         // output neuron counter
    logic [W_AW-1:0]   waddr_reg, waddr_next; // k * MAX_OUT + j, stepped
    logic              rd_issue;
    logic              rd_v_reg, rd_first_reg;
    logic              prod_v_reg;
    prod_t             prod_reg;
    acc_t              acc_reg, acc_next;

    logic [5:0]           out_idx_reg, out_idx_next;
    logic signed [RES_W-1:0] res_reg, res_next;
    logic                 last_reg, last_next;

    // ------------------------------------------------------------------
    // stores
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] x_rdata, w_rdata, b_rdata;
    logic [MAX_OUT-1:0] bias_vld_reg;

    dlf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_IN)
    ) u_input_ram (
        .aclk    (aclk),
        .wr_en   (elem_wr),
        .wr_addr (IN_AW'(s_row_index)),
        .wr_data (s_value),
        .rd_addr (k_reg),
        .rd_data (x_rdata)
    );

    dlf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (W_DEPTH)
    ) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (wgt_wr),
        .wr_addr (W_AW'(32'(s_row_index) * MAX_OUT + 32'(s_column_index))),
        .wr_data (s_value),
        .rd_addr (waddr_reg),
        .rd_data (w_rdata)
    );

    dlf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_OUT)
    ) u_bias_ram (
        .aclk    (aclk),
        .wr_en   (bias_wr),
        .wr_addr (OUT_AW'(s_column_index)),
        .wr_data (s_value),
        .rd_addr (j_reg),
        .rd_data (b_rdata)
    );

    // bias entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_vld_reg <= '0;
        end else if (bias_wr) begin
            bias_vld_reg[OUT_AW'(s_column_index)] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // shared mac: ram read -> product register -> accumulator
    // ------------------------------------------------------------------
    acc_t bias_term;
    acc_t shifted;
    logic signed [RES_W-1:0] sat_val;

    always_comb begin
        if (bias_en_reg && bias_vld_reg[j_reg]) begin
            bias_term = $signed({{(ACC_W-VAL_W){b_rdata[VAL_W-1]}}, b_rdata}) <<< FRAC_BITS;
        end else begin
            bias_term = '0;
        end

        // first read of a neuron seeds the sum with the bias
        priority if (rd_v_reg && rd_first_reg) begin
            acc_next = bias_term;
        end else if (prod_v_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg;
        end

        // floor shift back to twelve fraction bits, then saturate
        shifted = acc_reg >>> FRAC_BITS;
        priority if (!shifted[ACC_W-1] && (|shifted[ACC_W-2:RES_W-1])) begin
            sat_val = {1'b0, {(RES_W-1){1'b1}}};
        end else if (shifted[ACC_W-1] && !(&shifted[ACC_W-2:RES_W-1])) begin
            sat_val = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            sat_val = shifted[RES_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic k_last, j_last;

    assign k_last = (32'(k_reg) + 32'd1) == 32'(n_in);
    assign j_last = (32'(j_reg) + 32'd1) == 32'(n_out);

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        waddr_next   = waddr_reg;
        rd_issue     = 1'b0;
        out_idx_next = out_idx_reg;
        res_next     = res_reg;
        last_next    = last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (trigger) begin
                    state_next = ST_RUN;
                    j_next     = '0;
                    k_next     = '0;
                    waddr_next = '0;
                end
            end
            ST_RUN: begin
                // one element and one weight read per cycle
                rd_issue = 1'b1;
                if (k_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    k_next     = k_reg + IN_AW'(1);
                    waddr_next = W_AW'(32'(waddr_reg) + 32'(MAX_OUT));
                end
            end
            ST_FLUSH: begin
                // wait for the mac pipe to drain
                if (!rd_v_reg && !prod_v_reg) begin
                    state_next   = ST_OUT;
                    out_idx_next = 6'(j_reg);
                    res_next     = sat_val;
                    last_next    = j_last;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RUN;
                        j_next     = j_reg + OUT_AW'(1);
                        k_next     = '0;
                        waddr_next = W_AW'(j_reg + OUT_AW'(1));
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_v_reg     <= 1'b0;
            rd_first_reg <= 1'b0;
            prod_v_reg   <= 1'b0;
            acc_reg      <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            waddr_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            rd_v_reg     <= rd_issue;
            rd_first_reg <= rd_issue && (k_reg == '0);
            prod_v_reg   <= rd_v_reg;
            acc_reg      <= acc_next;
            k_reg        <= k_next;
            j_reg        <= j_next;
            waddr_reg    <= waddr_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        prod_reg    <= $signed(x_rdata) * $signed(w_rdata);
        out_idx_reg <= out_idx_next;
        res_reg     <= res_next;
        last_reg    <= last_next;
    end

    // ------------------------------------------------------------------
    // result item outputs
    // ------------------------------------------------------------------
    assign m_valid        = (state_reg == ST_OUT);
    assign m_out_index    = out_idx_reg;
    assign m_result_value = res_reg;
    assign m_last         = last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // no new item is taken while a result is on offer
    a_no_accept_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while result pending");

    // the final result of a burst hands control back to the input side
    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("block not idle after last result");

    // a triggering element always starts the mac run
    a_trigger_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        trigger |=> (state_reg == ST_RUN) && (k_reg == '0) && (j_reg == '0))
        else $error("burst did not start on trigger element");

    // result index stays inside the configured output count
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_out_index) < 32'(n_out)))
        else $error("result index beyond output count");

endmodule

// ===== rtl/dlf_ram.sv =====
// ----------------------------------------------------------------------------
// dlf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/tb_dense_layer_forward_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dense_layer_forward_top
// self-checking bench for the dense layer forward block: a queue-fed driver
// pushes weight, bias and vector element items, a predictor works out every
// neuron output, and a monitor compares each result item as it is accepted
// ----------------------------------------------------------------------------
module tb_dense_layer_forward_top;
    import dlf_pkg::*;

    localparam int         CLK_PERIOD    = 12;
    localparam int         CYCLE_LIMIT   = 600000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         IDLE_PCT      = 34;
    localparam int         MAX_PRINTS    = 50;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic signed [ACC_W-1:0] SAT_HI = 48'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_LO = -48'sd2147483648;

    typedef struct packed {
        logic [1:0]              op;
        logic [7:0]              row;
        logic [5:0]              col;
        logic signed [VAL_W-1:0] value;
    } layer_item_t;

    typedef struct packed {
        logic [5:0]              idx;
        logic signed [RES_W-1:0] value;
        logic                    last;
    } neuron_out_t;

    // clock, reset and block ports
    logic                          aclk;
    logic                          aresetn        = 1'b0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_op           = '0;
    logic [7:0]                    s_row_index    = '0;
    logic [5:0]                    s_column_index = '0;
    logic signed [VAL_W-1:0]       s_value        = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [5:0]                    m_out_index;
    logic signed [RES_W-1:0]       m_result_value;
    logic                          m_last;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index      = '0;
    logic [CFG_DATA_W-1:0]         cfg_data       = '0;

    // predictor copy of the layer: stores and registers
    logic signed [VAL_W-1:0] weight_mem [MAX_IN_DEF][MAX_OUT_DEF];
    logic signed [VAL_W-1:0] bias_mem   [MAX_OUT_DEF];
    logic signed [VAL_W-1:0] vector_mem [MAX_IN_DEF];
    logic [IN_LEN_W-1:0]     model_in_len   = 1;
    logic [OUT_LEN_W-1:0]    model_out_len  = 1;
    logic                    model_bias_on  = 1'b1;

    // stimulus side bookkeeping: which entries have been queued so far
    bit weight_seen [MAX_IN_DEF][MAX_OUT_DEF];
    bit elem_seen   [MAX_IN_DEF];
    int gen_in  = 1;
    int gen_out = 1;

    layer_item_t pending_items [$];
    neuron_out_t neuron_outputs [$];
    layer_item_t driven_item;
    neuron_out_t want;
    int          items_queued   = 0;
    int          items_accepted = 0;
    int          err_count      = 0;
    int          cycle_count    = 0;
    int          idle_pct       = IDLE_PCT;

    dense_layer_forward_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_row_index    (s_row_index),
        .s_column_index (s_column_index),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_index    (m_out_index),
        .m_result_value (m_result_value),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // a length of zero behaves as one, anything above the store size as the size
    function automatic int eff_in_len(int len);
        return (len == 0) ? 1 : (len > MAX_IN_DEF) ? MAX_IN_DEF : len;
    endfunction

    function automatic int eff_out_len(int len);
        return (len == 0) ? 1 : (len > MAX_OUT_DEF) ? MAX_OUT_DEF : len;
    endfunction

    // update the predicted stores with one accepted item; the final
    // element of a vector produces one expected output per neuron
    task automatic layer_accept(input layer_item_t it);
        int                      n_in;
        int                      n_out;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] bias_term;
        logic signed [ACC_W-1:0] scaled;
        neuron_out_t             res;
        n_in  = eff_in_len(int'(model_in_len));
        n_out = eff_out_len(int'(model_out_len));
        case (it.op)
            OP_WEIGHT: weight_mem[it.row][it.col] = it.value;
            OP_BIAS:   bias_mem[it.col] = it.value;
            OP_ELEM: begin
                vector_mem[it.row] = it.value;
                if (it.row == n_in - 1) begin
                    for (int j = 0; j < n_out; j++) begin
                        acc = '0;
                        for (int k = 0; k < n_in; k++)
                            acc = acc + vector_mem[k] * weight_mem[k][j];
                        if (model_bias_on) begin
                            bias_term = bias_mem[j];
                            acc = acc + (bias_term <<< FRAC_BITS_DEF);
                        end
                        // arithmetic shift rounds toward minus infinity
                        scaled = acc >>> FRAC_BITS_DEF;
                        res.idx   = j[5:0];
                        res.value = (scaled > SAT_HI) ? 32'sh7FFFFFFF :
                                    (scaled < SAT_LO) ? 32'sh80000000 : scaled[RES_W-1:0];
                        res.last  = (j == n_out - 1);
                        neuron_outputs = {neuron_outputs, res};
                    end
                end
            end
            default: ;  // unused op code, dropped by the block
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // input driver: presents queued items, idling at random between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                layer_accept(driven_item);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    driven_item    = pending_items.pop_front();
                    s_valid        <= 1'b1;
                    s_op           <= driven_item.op;
                    s_row_index    <= driven_item.row;
                    s_column_index <= driven_item.col;
                    s_value        <= driven_item.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random back-pressure, field by field comparison
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (neuron_outputs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, neuron %0d value %0d",
                                              m_out_index, m_result_value));
                end else begin
                    want = neuron_outputs.pop_front();
                    if (m_out_index !== want.idx)
                        report_mismatch($sformatf("out_index %0d, predicted %0d",
                                                  m_out_index, want.idx));
                    if (m_result_value !== want.value)
                        report_mismatch($sformatf("neuron %0d value %0d, predicted %0d",
                                                  want.idx, m_result_value, want.value));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("neuron %0d last %b, predicted %b",
                                                  want.idx, m_last, want.last));
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] op, input logic [7:0] row,
                              input logic [5:0] col, input logic signed [VAL_W-1:0] value);
        layer_item_t it;
        it = '{op: op, row: row, col: col, value: value};
        if (op == OP_WEIGHT)
            weight_seen[row][col] = 1'b1;
        if (op == OP_ELEM)
            elem_seen[row] = 1'b1;
        items_queued++;
        pending_items = {pending_items, it};
    endtask

    // block until every queued item is in and every output is out,
    // then give trailing writes time to land
    task automatic wait_idle();
        while (pending_items.size() != 0 || items_accepted != items_queued ||
               neuron_outputs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_INPUT_LENGTH:  model_in_len  = data[IN_LEN_W-1:0];
            CFG_OUTPUT_LENGTH: model_out_len = data[OUT_LEN_W-1:0];
            CFG_BIAS_ENABLE:   model_bias_on = data[0];
            default: ;
        endcase
    endtask

    // new layer shape, then make sure every weight it reads has a value
    task automatic set_layer(input logic [CFG_DATA_W-1:0] in_data,
                             input logic [CFG_DATA_W-1:0] out_data,
                             input logic [CFG_DATA_W-1:0] bias_data);
        wait_idle();
        write_reg(CFG_INPUT_LENGTH, in_data);
        write_reg(CFG_OUTPUT_LENGTH, out_data);
        write_reg(CFG_BIAS_ENABLE, bias_data);
        gen_in  = eff_in_len(int'(in_data[IN_LEN_W-1:0]));
        gen_out = eff_out_len(int'(out_data[OUT_LEN_W-1:0]));
        for (int k = 0; k < gen_in; k++)
            for (int j = 0; j < gen_out; j++)
                if (!weight_seen[k][j])
                    queue_item(OP_WEIGHT, 8'(k), 6'(j), rand_value());
    endtask

    // one complete vector, elements in shuffled order, trigger position last
    task automatic send_vector();
        int order [$];
        int pick;
        int tmp;
        for (int p = 0; p + 1 < gen_in; p++)
            order = {order, p};
        for (int i = order.size() - 1; i > 0; i--) begin
            pick = $urandom_range(i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        foreach (order[i])
            queue_item(OP_ELEM, 8'(order[i]), 6'($urandom), rand_value());
        queue_item(OP_ELEM, 8'(gen_in - 1), 6'($urandom), rand_value());
    endtask

    function automatic bit vector_complete();
        for (int p = 0; p + 1 < gen_in; p++)
            if (!elem_seen[p])
                return 1'b0;
        return 1'b1;
    endfunction

    // mostly whole vectors, with weight and bias updates, stray elements,
    // lone re-triggers and unused op codes mixed in
    task automatic random_phase(input int budget);
        int used;
        int pick;
        int row;
        used = 0;
        while (used < budget) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                if (gen_in <= 16) begin
                    send_vector();
                    used += gen_in;
                end
            end else if (pick < 55) begin
                // half the time inside the active window so it shows up
                if (pick[0])
                    queue_item(OP_WEIGHT, 8'($urandom_range(gen_in - 1)),
                               6'($urandom_range(gen_out - 1)), rand_value());
                else
                    queue_item(OP_WEIGHT, 8'($urandom), 6'($urandom), rand_value());
                used++;
            end else if (pick < 65) begin
                queue_item(OP_BIAS, 8'($urandom), 6'($urandom), rand_value());
                used++;
            end else if (pick < 73) begin
                queue_item(OP_UNUSED, 8'($urandom), 6'($urandom), rand_value());
            end else if (pick < 85) begin
                // stored only, never the trigger position
                row = $urandom_range(MAX_IN_DEF - 1);
                if (row == gen_in - 1)
                    row = (row + 1) % MAX_IN_DEF;
                queue_item(OP_ELEM, 8'(row), 6'($urandom), rand_value());
                used++;
            end else if (vector_complete()) begin
                queue_item(OP_ELEM, 8'(gen_in - 1), 6'($urandom), rand_value());
                used++;
            end
        end
    endtask

    initial begin
        foreach (bias_mem[j])
            bias_mem[j] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset shape of one by one with bias on, extreme values
        queue_item(OP_WEIGHT, 8'd0, 6'd0, 16'sh7FFF);
        queue_item(OP_ELEM, 8'd0, 6'd63, 16'sh7FFF);
        queue_item(OP_BIAS, 8'd255, 6'd0, 16'sh8000);
        queue_item(OP_ELEM, 8'd0, 6'd0, 16'sh8000);
        queue_item(OP_WEIGHT, 8'd0, 6'd0, 16'sh8000);
        queue_item(OP_ELEM, 8'd0, 6'd21, 16'sh8000);
        queue_item(OP_UNUSED, 8'd255, 6'd63, 16'shFFFF);
        queue_item(OP_ELEM, 8'd0, 6'd42, 16'shFFFF);
        queue_item(OP_BIAS, 8'd0, 6'd63, 16'sh7FFF);
        queue_item(OP_WEIGHT, 8'd255, 6'd63, 16'sh7FFF);
        queue_item(OP_ELEM, 8'd255, 6'd0, 16'sh0001);
        // small negative products below one lsb must floor to -1
        queue_item(OP_WEIGHT, 8'd0, 6'd0, 16'shFFFF);
        queue_item(OP_BIAS, 8'd170, 6'd0, 16'sh0000);
        queue_item(OP_ELEM, 8'd0, 6'd0, 16'sh0001);
        queue_item(OP_ELEM, 8'd0, 6'd0, 16'sh0000);

        set_layer(9'd3, 9'd4, 9'd1);
        random_phase(20);
        // zero lengths behave as one
        set_layer(9'd0, 9'd0, 9'd0);
        random_phase(12);
        // longer vector
        set_layer(9'd20, 9'd2, 9'd1);
        send_vector();
        random_phase(6);
        // widest output
        set_layer(9'd1, 9'd64, 9'd0);
        random_phase(12);
        // input length above the store size clamps, so only position 255
        // could start a burst and stray elements elsewhere stay silent
        wait_idle();
        write_reg(CFG_INPUT_LENGTH, 9'd511);
        gen_in = eff_in_len(int'(model_in_len));
        random_phase(6);
        // output length above the store size clamps
        set_layer(9'd1, 9'd127, 9'd1);
        random_phase(8);

        // a stretch with no idling on either side
        idle_pct = 0;
        repeat (2) begin
            set_layer(9'($urandom_range(1, 8)), 9'($urandom_range(1, 6)),
                      9'($urandom_range(1)));
            random_phase(15);
        end
        idle_pct = IDLE_PCT;

        // unused upper data bits of the narrow registers carry noise
        repeat (3) begin
            set_layer(9'($urandom_range(1, 8)),
                      {2'($urandom), 7'($urandom_range(1, 6))},
                      {8'($urandom), 1'($urandom)});
            random_phase(10);
        end

        wait_idle();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
